// ===== src/dpar_pkg.sv =====
// Package for the direction pad auto-repeat block: payload types, register codes and reset values.
package dpar_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_DELAY   = 2'd0,
    CFG_REPEAT_INTERVAL = 2'd1
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] INITIAL_DELAY_RST   = 16'd350;
  localparam logic [CFG_DATA_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  typedef struct packed {
    logic              pad_up;
    logic              pad_down;
    logic              pad_left;
    logic              pad_right;
    logic              confirm_button;
    logic              cancel_button;
    logic              menu_button;
    logic              bags_button;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       nav_valid;
    logic [1:0] nav_direction;
    logic       confirm_pulse;
    logic       cancel_pulse;
    logic       menu_pulse;
    logic       bags_pulse;
  } out_t;

endpackage

// ===== src/dpar_core.sv =====
// Held-direction tracking, repeat timing and button edge detection for one poll sample.
module dpar_core import dpar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  in_t                   sample,
  input  logic [CFG_DATA_W-1:0] initial_delay,
  input  logic [CFG_DATA_W-1:0] repeat_interval,
  output out_t                  result
);

  logic              held_vld_r, held_vld_nxt;
  logic [1:0]        held_dir_r, held_dir_nxt;
  logic [TIME_W-1:0] due_r, due_nxt;
  logic [3:0]        last_dirs_r;
  logic [3:0]        last_btns_r;

  logic [3:0]        dirs, btns, fresh;
  logic              have_new, opposing, press, release_hit, fire;
  logic              hv1, hv2, rearm;
  logic [1:0]        newest, hd1, hd2;
  logic [TIME_W-1:0] sum_init, sum_rep, diff_stored, due2;

  function automatic logic [1:0] top_bit(input logic [3:0] v);
    logic [1:0] r;
    r = 2'd0;
    if (v[1]) r = 2'd1;
    if (v[2]) r = 2'd2;
    if (v[3]) r = 2'd3;
    return r;
  endfunction

  assign dirs = {sample.pad_right, sample.pad_left, sample.pad_down, sample.pad_up};
  assign btns = {sample.bags_button, sample.menu_button, sample.cancel_button,
                 sample.confirm_button};

  assign sum_init    = sample.now_ms + {{(TIME_W-CFG_DATA_W){1'b0}}, initial_delay};
  assign sum_rep     = sample.now_ms + {{(TIME_W-CFG_DATA_W){1'b0}}, repeat_interval};
  assign diff_stored = sample.now_ms - due_r;

  always_comb begin
    fresh    = dirs & ~last_dirs_r;
    have_new = |fresh;
    newest   = top_bit(fresh);
    opposing = (dirs[1:0] == 2'b11) || (dirs[3:2] == 2'b11);
    press    = !opposing && have_new;

    hv1 = press ? 1'b1 : held_vld_r;
    hd1 = press ? newest : held_dir_r;

    release_hit = hv1 && !dirs[hd1];
    hv2 = release_hit ? (|dirs) : hv1;
    hd2 = release_hit ? top_bit(dirs) : hd1;
    rearm = press || release_hit;

    if (release_hit) begin
      due2 = (|dirs) ? sum_init : '0;
    end else if (press) begin
      due2 = sum_init;
    end else begin
      due2 = due_r;
    end

    // Right after a re-arm, now minus due is minus the initial delay, which is
    // not negative only when that delay is zero.
    fire = !opposing && hv2 &&
           (rearm ? (initial_delay == '0) : !diff_stored[TIME_W-1]);

    held_vld_nxt = opposing ? 1'b0 : hv2;
    held_dir_nxt = hd2;
    if (fire) begin
      due_nxt = sum_rep;
    end else if (opposing) begin
      due_nxt = '0;
    end else begin
      due_nxt = due2;
    end

    result.nav_valid     = press || fire;
    result.nav_direction = fire ? hd2 : (press ? newest : 2'd0);
    result.confirm_pulse = btns[0] && !last_btns_r[0];
    result.cancel_pulse  = btns[1] && !last_btns_r[1];
    result.menu_pulse    = btns[2] && !last_btns_r[2];
    result.bags_pulse    = btns[3] && !last_btns_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r  <= 1'b0;
      held_dir_r  <= 2'd0;
      due_r       <= '0;
      last_dirs_r <= 4'd0;
      last_btns_r <= 4'd0;
    end else if (step) begin
      held_vld_r  <= held_vld_nxt;
      held_dir_r  <= held_dir_nxt;
      due_r       <= due_nxt;
      last_dirs_r <= dirs;
      last_btns_r <= btns;
    end
  end

  // A held direction is always one that the last sample had pressed.
  a_held_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    held_vld_r |-> last_dirs_r[held_dir_r])
    else $error("held direction is not pressed");

  a_opposing_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && opposing |=> !held_vld_r && (due_r == '0))
    else $error("opposing pair did not cancel repeat");

endmodule

// ===== src/direction_pad_auto_repeat.sv =====
// Top level of the direction pad auto-repeat block: registers, handshakes and configuration.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_data (in_t): buttons and now_ms
//   out      output     out_valid/out_stall out_data (out_t): nav command and pulses
//   cfg      input      cfg_we              cfg_index, cfg_wdata (16 bit)
//
// One sample is accepted per cycle while in_stall is low. It passes from the
// input register to the result register on out_data, and leaves there once
// out_stall is low. The input register and the result register bound one
// pass of logic. Reset is synchronous: both registers empty, repeat state
// cleared, delays back at 350 ms and 100 ms. A stalled result holds the
// result register, and the input register then stalls once it is also full.
module direction_pad_auto_repeat import dpar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  in_vld_r;
  in_t                   in_data_r;
  logic                  out_vld_r;
  out_t                  out_data_r;
  logic [CFG_DATA_W-1:0] initial_delay_r;
  logic [CFG_DATA_W-1:0] repeat_interval_r;
  logic                  step;
  out_t                  result;

  assign step     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  dpar_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .sample          (in_data_r),
    .initial_delay   (initial_delay_r),
    .repeat_interval (repeat_interval_r),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r   <= INITIAL_DELAY_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_DELAY:   initial_delay_r   <= cfg_wdata;
        CFG_REPEAT_INTERVAL: repeat_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("processed sample left no result");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && out_stall |-> in_stall && !step)
    else $error("sample advanced into a stalled result register");

  a_quiet_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.nav_valid |-> out_data_r.nav_direction == 2'd0)
    else $error("direction set without a navigation command");

endmodule

// ===== tb/sv/direction_pad_auto_repeat_test.sv =====
// Self-checking testbench for the direction pad auto-repeat block.
`timescale 1ns / 1ps

module direction_pad_auto_repeat_test;
  import dpar_pkg::*;

  localparam logic [3:0] PAD_NONE  = 4'b0000;
  localparam logic [3:0] PAD_UP    = 4'b0001;
  localparam logic [3:0] PAD_DOWN  = 4'b0010;
  localparam logic [3:0] PAD_LEFT  = 4'b0100;
  localparam logic [3:0] PAD_RIGHT = 4'b1000;
  localparam logic [3:0] PAD_ALL   = 4'b1111;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  direction_pad_auto_repeat i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predicted block state and its copy of the delay registers.
  logic [15:0] first_delay   = INITIAL_DELAY_RST;
  logic [15:0] repeat_gap    = REPEAT_INTERVAL_RST;
  logic        held_on       = 1'b0;
  logic [1:0]  held_dir      = 2'd0;
  logic [31:0] due_ms        = 32'd0;
  logic [3:0]  pad_prev      = 4'd0;
  logic [3:0]  btn_prev      = 4'd0;

  in_t   poll_q[$];
  out_t  expected_cmds[$];
  bit    idle_en = 1'b0;
  int    send_gap = 0;
  int    stall_left = 0;
  int    mismatches = 0;
  int    polls_sent = 0;
  int    navs_seen = 0;
  int    pulses_seen = 0;
  int    cfg_writes = 0;

  // Stimulus generator state.
  logic [3:0]  gen_dirs = PAD_NONE;
  logic [3:0]  gen_btns = 4'd0;
  logic [31:0] gen_now = 32'd0;

  function automatic out_t predict_nav(in_t s);
    logic [3:0]  dirs;
    logic [3:0]  btns;
    logic        have_new;
    logic        opposing;
    logic [1:0]  newest;
    logic [31:0] diff;
    out_t        r;
    dirs = {s.pad_right, s.pad_left, s.pad_down, s.pad_up};
    btns = {s.bags_button, s.menu_button, s.cancel_button, s.confirm_button};
    r = '0;
    have_new = 1'b0;
    newest = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (dirs[i] && !pad_prev[i]) begin
        newest = 2'(i);
        have_new = 1'b1;
      end
    end
    opposing = (dirs[1:0] == 2'b11) || (dirs[3:2] == 2'b11);
    if (!opposing && have_new) begin
      held_on = 1'b1;
      held_dir = newest;
      r.nav_valid = 1'b1;
      r.nav_direction = newest;
      due_ms = s.now_ms + 32'(first_delay);
    end
    // Releasing the held direction hands over to the highest one still down, silently unless the initial delay is zero.
    if (held_on && !dirs[held_dir]) begin
      held_on = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (dirs[i]) begin
          held_on = 1'b1;
          held_dir = 2'(i);
        end
      end
      due_ms = held_on ? s.now_ms + 32'(first_delay) : 32'd0;
    end
    if (opposing) begin
      held_on = 1'b0;
      due_ms = 32'd0;
    end
    diff = s.now_ms - due_ms;
    if (held_on && !diff[31]) begin
      r.nav_valid = 1'b1;
      r.nav_direction = held_dir;
      due_ms = s.now_ms + 32'(repeat_gap);
    end
    pad_prev = dirs;
    r.confirm_pulse = btns[0] & ~btn_prev[0];
    r.cancel_pulse  = btns[1] & ~btn_prev[1];
    r.menu_pulse    = btns[2] & ~btn_prev[2];
    r.bags_pulse    = btns[3] & ~btn_prev[3];
    btn_prev = btns;
    return r;
  endfunction

  // Driver: presents queued poll samples and records a prediction for every transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_cmds.push_back(predict_nav(in_data));
        polls_sent++;
      end
      if (in_valid && in_stall) begin
        // The stalled sample stays on the bus unchanged.
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (poll_q.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else if (poll_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= poll_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: throttles the result side and checks every transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $error("result transfer with no sample outstanding: %p", out_data);
          mismatches++;
        end else begin
          out_t want;
          want = expected_cmds.pop_front();
          if (out_data.nav_valid !== want.nav_valid) begin
            $error("nav_valid: expected %0d, got %0d", want.nav_valid, out_data.nav_valid);
            mismatches++;
          end
          if (out_data.nav_direction !== want.nav_direction) begin
            $error("nav_direction: expected %0d, got %0d",
                   want.nav_direction, out_data.nav_direction);
            mismatches++;
          end
          if (out_data.confirm_pulse !== want.confirm_pulse) begin
            $error("confirm_pulse: expected %0d, got %0d",
                   want.confirm_pulse, out_data.confirm_pulse);
            mismatches++;
          end
          if (out_data.cancel_pulse !== want.cancel_pulse) begin
            $error("cancel_pulse: expected %0d, got %0d",
                   want.cancel_pulse, out_data.cancel_pulse);
            mismatches++;
          end
          if (out_data.menu_pulse !== want.menu_pulse) begin
            $error("menu_pulse: expected %0d, got %0d", want.menu_pulse, out_data.menu_pulse);
            mismatches++;
          end
          if (out_data.bags_pulse !== want.bags_pulse) begin
            $error("bags_pulse: expected %0d, got %0d", want.bags_pulse, out_data.bags_pulse);
            mismatches++;
          end
          if (want.nav_valid) navs_seen++;
          pulses_seen += want.confirm_pulse + want.cancel_pulse + want.menu_pulse
                         + want.bags_pulse;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic post(logic [3:0] dirs, logic [3:0] btns, logic [31:0] now);
    in_t s;
    s.pad_up         = dirs[0];
    s.pad_down       = dirs[1];
    s.pad_left       = dirs[2];
    s.pad_right      = dirs[3];
    s.confirm_button = btns[0];
    s.cancel_button  = btns[1];
    s.menu_button    = btns[2];
    s.bags_button    = btns[3];
    s.now_ms         = now;
    gen_dirs = dirs;
    gen_btns = btns;
    gen_now  = now;
    poll_q.push_back(s);
  endtask

  // Waits until the block has no sample in flight and every result has arrived.
  task automatic drain();
    do @(negedge clk);
    while (poll_q.size() != 0 || in_valid || expected_cmds.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_INITIAL_DELAY:   first_delay = value;
      CFG_REPEAT_INTERVAL: repeat_gap = value;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly held directions with occasional presses, releases and chords; some noise.
  task automatic gen_samples(int count, int unsigned step_max);
    logic [3:0]  dirs;
    logic [3:0]  btns;
    logic [31:0] now;
    for (int n = 0; n < count; n++) begin
      dirs = gen_dirs;
      btns = gen_btns;
      case ($urandom_range(0, 11))
        0: dirs = 4'($urandom);
        1, 2: dirs = PAD_UP << $urandom_range(0, 3);
        3: dirs = dirs | (PAD_UP << $urandom_range(0, 3));
        4: dirs = dirs & ~(PAD_UP << $urandom_range(0, 3));
        5: dirs = PAD_NONE;
        default: ;
      endcase
      if ($urandom_range(0, 2) == 0) btns = btns ^ (4'b0001 << $urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) now = $urandom;
      else now = gen_now + $urandom_range(0, step_max);
      post(dirs, btns, now);
    end
  endtask

  task automatic random_config(output int unsigned step_max);
    logic [15:0] d;
    logic [15:0] g;
    case ($urandom_range(0, 3))
      0: d = 16'd0;
      1: d = 16'($urandom_range(1, 40));
      2: d = 16'($urandom_range(41, 2000));
      default: d = 16'($urandom_range(2001, 65535));
    endcase
    case ($urandom_range(0, 2))
      0: g = 16'($urandom_range(1, 20));
      1: g = 16'($urandom_range(21, 3000));
      default: g = 16'($urandom_range(3001, 65535));
    endcase
    write_reg(CFG_INITIAL_DELAY, d);
    write_reg(CFG_REPEAT_INTERVAL, g);
    step_max = (int'(g) + int'(d) / 6) / 2 + 1;
  endtask

  initial begin
    int unsigned step_max;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_en = 1'b1;

    // Reset delays: first press, exact repeat boundaries, takeover, opposing pairs, wrap.
    post(PAD_NONE, 4'b0000, 32'd0);
    post(PAD_NONE, 4'b1111, 32'hFFFF_FFFF);
    post(PAD_NONE, 4'b0000, 32'd1000);
    post(PAD_UP, 4'b0101, 32'd1000);
    post(PAD_UP, 4'b0000, 32'd1349);
    post(PAD_UP, 4'b1010, 32'd1350);
    post(PAD_UP, 4'b1010, 32'd1449);
    post(PAD_UP, 4'b0000, 32'd1450);
    post(PAD_UP | PAD_RIGHT, 4'b0001, 32'd1460);
    post(PAD_UP, 4'b0010, 32'd1470);
    post(PAD_UP, 4'b0100, 32'd1820);
    post(PAD_UP | PAD_DOWN | PAD_LEFT, 4'b1000, 32'd1830);
    post(PAD_LEFT, 4'b0000, 32'd1840);
    post(PAD_NONE, 4'b0000, 32'd1850);
    post(PAD_ALL, 4'b0000, 32'd1860);
    post(PAD_NONE, 4'b0000, 32'd1870);
    post(PAD_DOWN | PAD_RIGHT, 4'b0000, 32'd1880);
    post(PAD_DOWN | PAD_RIGHT, 4'b0000, 32'hFFFF_FF00);
    post(PAD_NONE, 4'b0000, 32'hFFFF_FF00);
    post(PAD_LEFT, 4'b0000, 32'hFFFF_FF00);
    post(PAD_LEFT, 4'b0000, 32'h0000_005E);
    post(PAD_LEFT, 4'b0000, 32'h8000_00C2);
    post(PAD_LEFT, 4'b0000, 32'h8000_00C3);
    post(PAD_LEFT | PAD_RIGHT, 4'b0000, 32'h8000_00C4);
    drain();

    // Zero delay and zero interval: a press repeats in its own sample and on every later one.
    write_reg(CFG_INITIAL_DELAY, 16'd0);
    write_reg(CFG_REPEAT_INTERVAL, 16'd0);
    post(PAD_NONE, 4'b0000, 32'd500);
    post(PAD_DOWN, 4'b0000, 32'd500);
    post(PAD_DOWN, 4'b0000, 32'd500);
    post(PAD_DOWN, 4'b0000, 32'd501);
    gen_samples(40, 3);
    drain();

    // Largest delays, sender and receiver starting no new gaps or stall bursts.
    idle_en = 1'b0;
    write_reg(CFG_INITIAL_DELAY, 16'hFFFF);
    write_reg(CFG_REPEAT_INTERVAL, 16'hFFFF);
    post(PAD_NONE, 4'b0000, 32'd10);
    post(PAD_RIGHT, 4'b0000, 32'd10);
    post(PAD_RIGHT, 4'b0000, 32'd65544);
    post(PAD_RIGHT, 4'b0000, 32'd65545);
    post(PAD_RIGHT, 4'b0000, 32'd131080);
    gen_samples(40, 30000);
    drain();

    idle_en = 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        // Let any stall burst still running finish so the last phase has no idling.
        idle_en = 1'b0;
        wait (stall_left == 0 && send_gap == 0);
      end
      random_config(step_max);
      gen_samples(75, step_max);
      drain();
    end

    $display("Sent %0d poll samples over %0d register writes; checked %0d nav commands",
             polls_sent, cfg_writes, navs_seen);
    $display("and %0d button pulses, across wrap, opposing and takeover cases.", pulses_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
